FILE: hdl/hpc_pkg.sv
// hpc_pkg: shared constants, register indexes and stage control type for
// the heading pi controller. No dependencies.
package hpc_pkg;

  // angle domain, 1/16 degree, held in 14 bit signed arithmetic
  localparam logic signed [13:0] HALF_TURN    = 14'sd2880;
  localparam logic signed [13:0] ONE_TURN     = 14'sd5760;
  localparam logic signed [13:0] INTEG_WINDOW = 14'sd64;
  localparam logic signed [13:0] SETTLE_ANGLE = 14'sd16;

  // rate domain, 1/16 dps
  localparam logic [11:0] RATE_MAX    = 12'd2880;
  localparam logic [16:0] SETTLE_RATE = 17'd1600;

  // drive limits in whole percent
  localparam int DRIVE_FLOOR = 10;
  localparam int DRIVE_CEIL  = 100;
  localparam int FRAC_BITS   = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_HEADING      = 3'd0,
    REG_RATE_LIMIT          = 3'd1,
    REG_ANGLE_GAIN          = 3'd2,
    REG_ANGLE_INTEGRAL_GAIN = 3'd3,
    REG_RATE_GAIN           = 3'd4,
    REG_RATE_INTEGRAL_GAIN  = 3'd5
  } cfg_idx_t;

  localparam logic signed [12:0] RST_TARGET_HEADING      = 13'sd0;
  localparam logic [11:0]        RST_RATE_LIMIT          = 12'd0;
  localparam logic [15:0]        RST_ANGLE_GAIN          = 16'd16384;
  localparam logic [15:0]        RST_ANGLE_INTEGRAL_GAIN = 16'd16;
  localparam logic [15:0]        RST_RATE_GAIN           = 16'd2277;
  localparam logic [15:0]        RST_RATE_INTEGRAL_GAIN  = 16'd41;

  // load strobes for the internal pipeline stages
  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic s3_load;
  } hpc_ctl_t;

endpackage

FILE: hdl/heading_pi_controller.sv
// heading_pi_controller: top level with configuration registers, input and
// result registers and the stage handshake. Uses hpc_pkg, hpc_error, hpc_gain.
//
//   channel | ports                                          | direction
//   input   | in_valid, in_stall, in_facing, in_yaw_rate     | sample in
//   result  | out_valid, out_stall, out_rotation_drive,      | drive out
//           | out_settled, out_heading_error                 |
//   config  | cfg_we, cfg_idx, cfg_data                      | write only
//
// one sample per cycle unless in_stall; a result passes s1, s2, s3 and the
// output register after its input transfer. the rate is set by the integral
// update in hpc_error, one add and saturate per cycle. every stage holds its
// own valid bit, so bubbles close up and input keeps flowing while a result
// waits. reset clears valids, integrals and configuration to their defaults.
module heading_pi_controller #(
  parameter int ACC_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [12:0]                in_facing,
  input  logic signed [15:0]                in_yaw_rate,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [7:0]                 out_rotation_drive,
  output logic                              out_settled,
  output logic signed [12:0]                out_heading_error,
  input  logic                              cfg_we,
  input  logic [hpc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [hpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hpc_pkg::*;

  localparam int PW   = ACC_WIDTH + 18;
  localparam int DQ_W = PW - FRAC_BITS;

  // configuration
  logic signed [12:0] target_r;
  logic [11:0]        rate_limit_r;
  logic [15:0]        angle_gain_r, angle_igain_r, rate_gain_r, rate_igain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r      <= RST_TARGET_HEADING;
      rate_limit_r  <= RST_RATE_LIMIT;
      angle_gain_r  <= RST_ANGLE_GAIN;
      angle_igain_r <= RST_ANGLE_INTEGRAL_GAIN;
      rate_gain_r   <= RST_RATE_GAIN;
      rate_igain_r  <= RST_RATE_INTEGRAL_GAIN;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TARGET_HEADING:      target_r      <= cfg_data[12:0];
        REG_RATE_LIMIT:          rate_limit_r  <= cfg_data[11:0];
        REG_ANGLE_GAIN:          angle_gain_r  <= cfg_data;
        REG_ANGLE_INTEGRAL_GAIN: angle_igain_r <= cfg_data;
        REG_RATE_GAIN:           rate_gain_r   <= cfg_data;
        REG_RATE_INTEGRAL_GAIN:  rate_igain_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and handshake
  logic     s0_v_r, s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic     o_free, s3_free, s2_free, s1_free, s0_free, out_load, in_load;
  hpc_ctl_t ctl;

  always_comb begin
    o_free      = !out_v_r || !out_stall;
    s3_free     = !s3_v_r || o_free;
    s2_free     = !s2_v_r || s3_free;
    s1_free     = !s1_v_r || s2_free;
    s0_free     = !s0_v_r || s1_free;
    ctl.s1_load = s1_free && s0_v_r;
    ctl.s2_load = s2_free && s1_v_r;
    ctl.s3_load = s3_free && s2_v_r;
    out_load    = o_free && s3_v_r;
    in_load     = s0_free && in_valid;
  end

  assign in_stall  = !s0_free;
  assign out_valid = out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s0_free) s0_v_r  <= in_valid;
      if (s1_free) s1_v_r  <= s0_v_r;
      if (s2_free) s2_v_r  <= s1_v_r;
      if (s3_free) s3_v_r  <= s2_v_r;
      if (o_free)  out_v_r <= s3_v_r;
    end
  end

  // input register
  logic signed [12:0] facing_r;
  logic signed [15:0] yaw_r;

  always_ff @(posedge clk) begin
    if (in_load) begin
      facing_r <= in_facing;
      yaw_r    <= in_yaw_rate;
    end
  end

  logic signed [12:0]          err1, err3;
  logic                        settled1, settled3;
  logic [11:0]                 lim1;
  logic signed [ACC_WIDTH-1:0] ang_acc, rate_acc;
  logic signed [PW-1:0]        drive_sum, cap_sum;

  hpc_error #(.ACC_WIDTH(ACC_WIDTH)) u_error (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .facing         (facing_r),
    .yaw_rate       (yaw_r),
    .target_heading (target_r),
    .rate_limit     (rate_limit_r),
    .err_r          (err1),
    .settled_r      (settled1),
    .lim_r          (lim1),
    .ang_acc_r      (ang_acc),
    .rate_acc_r     (rate_acc)
  );

  hpc_gain #(.ACC_WIDTH(ACC_WIDTH)) u_gain (
    .clk                 (clk),
    .ctl                 (ctl),
    .err                 (err1),
    .settled             (settled1),
    .lim                 (lim1),
    .ang_acc             (ang_acc),
    .rate_acc            (rate_acc),
    .angle_gain          (angle_gain_r),
    .angle_integral_gain (angle_igain_r),
    .rate_gain           (rate_gain_r),
    .rate_integral_gain  (rate_igain_r),
    .drive_sum_r         (drive_sum),
    .cap_sum_r           (cap_sum),
    .err3_r              (err3),
    .settled3_r          (settled3)
  );

  // truncate towards zero, clamp the limit, then clamp the drive
  logic signed [PW-1:0]   drv_adj;
  logic signed [DQ_W-1:0] drv_q, cap_q;
  logic [7:0]             cap;
  logic signed [8:0]      cap_s;
  logic signed [7:0]      drive_nxt;

  always_comb begin
    drv_adj = drive_sum + (drive_sum[PW-1] ? PW'((1 << FRAC_BITS) - 1) : PW'(0));
    drv_q   = drv_adj[PW-1:FRAC_BITS];
    cap_q   = cap_sum[PW-1:FRAC_BITS];
    if (cap_q < DRIVE_FLOOR) begin
      cap = 8'(DRIVE_FLOOR);
    end else if (cap_q > DRIVE_CEIL) begin
      cap = 8'(DRIVE_CEIL);
    end else begin
      cap = cap_q[7:0];
    end
    cap_s = $signed({1'b0, cap});
    if (drv_q > cap_s) begin
      drive_nxt = cap_s[7:0];
    end else if (drv_q < -cap_s) begin
      drive_nxt = 8'(-cap_s);
    end else begin
      drive_nxt = drv_q[7:0];
    end
  end

  logic signed [7:0]  out_drive_r;
  logic               out_settled_r;
  logic signed [12:0] out_err_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_settled_r <= settled3;
      out_drive_r   <= settled3 ? 8'sd0 : drive_nxt;
      out_err_r     <= settled3 ? 13'sd0 : err3;
    end
  end

  assign out_rotation_drive = out_drive_r;
  assign out_settled        = out_settled_r;
  assign out_heading_error  = out_err_r;

endmodule

FILE: hdl/hpc_error.sv
// hpc_error: heading error, rate shortfall and the two saturating integrals.
// Depends on hpc_pkg. The integral registers double as this stage's output.
module hpc_error #(
  parameter int ACC_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hpc_pkg::hpc_ctl_t           ctl,
  input  logic signed [12:0]          facing,
  input  logic signed [15:0]          yaw_rate,
  input  logic signed [12:0]          target_heading,
  input  logic [11:0]                 rate_limit,
  output logic signed [12:0]          err_r,
  output logic                        settled_r,
  output logic [11:0]                 lim_r,
  output logic signed [ACC_WIDTH-1:0] ang_acc_r,
  output logic signed [ACC_WIDTH-1:0] rate_acc_r
);
  import hpc_pkg::*;

  localparam int SUM_W = ((ACC_WIDTH > 18) ? ACC_WIDTH : 18) + 1;

  logic signed [13:0]          tgt_ext, tgt_w, err_raw, aerr_raw, err_wrap, aerr_wrap;
  logic signed [16:0]          yaw_ext;
  logic [16:0]                 ayaw;
  logic [11:0]                 lim;
  logic signed [17:0]          shortfall;
  logic signed [SUM_W-1:0]     ang_sum, rate_sum;
  logic signed [ACC_WIDTH-1:0] ang_sat, rate_sat;
  logic                        in_window, settle;
  logic signed [ACC_WIDTH-1:0] ang_acc_nxt, rate_acc_nxt;

  function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (v[SUM_W-1:ACC_WIDTH-1] == {(SUM_W-ACC_WIDTH+1){1'b0}}) ||
           (v[SUM_W-1:ACC_WIDTH-1] == {(SUM_W-ACC_WIDTH+1){1'b1}});
    if (fits) begin
      sat_acc = v[ACC_WIDTH-1:0];
    end else if (v[SUM_W-1]) begin
      sat_acc = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    end else begin
      sat_acc = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end
  endfunction

  always_comb begin
    tgt_ext = {target_heading[12], target_heading};
    if (tgt_ext > HALF_TURN) begin
      tgt_w = tgt_ext - ONE_TURN;
    end else if (tgt_ext < -HALF_TURN) begin
      tgt_w = tgt_ext + ONE_TURN;
    end else begin
      tgt_w = tgt_ext;
    end

    err_raw  = tgt_w - {facing[12], facing};
    aerr_raw = err_raw[13] ? -err_raw : err_raw;
    in_window = aerr_raw < INTEG_WINDOW;

    if (err_raw > HALF_TURN) begin
      err_wrap = err_raw - ONE_TURN;
    end else if (err_raw < -HALF_TURN) begin
      err_wrap = err_raw + ONE_TURN;
    end else begin
      err_wrap = err_raw;
    end
    aerr_wrap = err_wrap[13] ? -err_wrap : err_wrap;

    yaw_ext = {yaw_rate[15], yaw_rate};
    ayaw    = yaw_rate[15] ? 17'(-yaw_ext) : 17'(yaw_ext);
    lim     = (rate_limit > RATE_MAX) ? RATE_MAX : rate_limit;
    shortfall = $signed({6'd0, lim}) - $signed({1'b0, ayaw});

    settle = (aerr_wrap < SETTLE_ANGLE) && (ayaw < SETTLE_RATE);

    ang_sum  = $signed({{(SUM_W-ACC_WIDTH){ang_acc_r[ACC_WIDTH-1]}}, ang_acc_r}) +
               $signed({{(SUM_W-14){err_raw[13]}}, err_raw});
    rate_sum = $signed({{(SUM_W-ACC_WIDTH){rate_acc_r[ACC_WIDTH-1]}}, rate_acc_r}) +
               $signed({{(SUM_W-18){shortfall[17]}}, shortfall});
    ang_sat  = sat_acc(ang_sum);
    rate_sat = sat_acc(rate_sum);

    // a settled item clears both integrals; its drive is forced to zero later
    if (settle) begin
      ang_acc_nxt  = '0;
      rate_acc_nxt = '0;
    end else begin
      ang_acc_nxt  = in_window ? ang_sat : '0;
      rate_acc_nxt = rate_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_acc_r  <= '0;
      rate_acc_r <= '0;
    end else if (ctl.s1_load) begin
      ang_acc_r  <= ang_acc_nxt;
      rate_acc_r <= rate_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      err_r     <= err_wrap[12:0];
      settled_r <= settle;
      lim_r     <= lim;
    end
  end

endmodule

FILE: hdl/hpc_gain.sv
// hpc_gain: gain products (one register stage) and the drive and limit sums
// (a second register stage). Depends on hpc_pkg.
module hpc_gain #(
  parameter int ACC_WIDTH = 24
) (
  input  logic                         clk,
  input  hpc_pkg::hpc_ctl_t            ctl,
  input  logic signed [12:0]           err,
  input  logic                         settled,
  input  logic [11:0]                  lim,
  input  logic signed [ACC_WIDTH-1:0]  ang_acc,
  input  logic signed [ACC_WIDTH-1:0]  rate_acc,
  input  logic [15:0]                  angle_gain,
  input  logic [15:0]                  angle_integral_gain,
  input  logic [15:0]                  rate_gain,
  input  logic [15:0]                  rate_integral_gain,
  output logic signed [ACC_WIDTH+17:0] drive_sum_r,
  output logic signed [ACC_WIDTH+17:0] cap_sum_r,
  output logic signed [12:0]           err3_r,
  output logic                         settled3_r
);
  import hpc_pkg::*;

  localparam int PI_W = ACC_WIDTH + 17;
  localparam int PW   = ACC_WIDTH + 18;

  logic signed [29:0]   p_ang_nxt, p_ang_r;
  logic signed [PI_W-1:0] p_ai_nxt, p_ai_r, p_ri_nxt, p_ri_r;
  logic [27:0]          p_rg_nxt, p_rg_r;
  logic signed [12:0]   err2_r;
  logic                 settled2_r;

  always_comb begin
    p_ang_nxt = $signed({1'b0, angle_gain}) * err;
    p_ai_nxt  = $signed({1'b0, angle_integral_gain}) * ang_acc;
    p_rg_nxt  = rate_gain * lim;
    p_ri_nxt  = $signed({1'b0, rate_integral_gain}) * rate_acc;
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      p_ang_r    <= p_ang_nxt;
      p_ai_r     <= p_ai_nxt;
      p_rg_r     <= p_rg_nxt;
      p_ri_r     <= p_ri_nxt;
      err2_r     <= err;
      settled2_r <= settled;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s3_load) begin
      drive_sum_r <= PW'(p_ang_r) + PW'(p_ai_r);
      cap_sum_r   <= $signed(PW'(p_rg_r)) + PW'(p_ri_r);
      err3_r      <= err2_r;
      settled3_r  <= settled2_r;
    end
  end

endmodule
